// ===== sv/packet_command_responder_defines.svh =====
// Assertion macros shared by the packet command responder modules
`ifndef PACKET_COMMAND_RESPONDER_DEFINES_SVH
`define PACKET_COMMAND_RESPONDER_DEFINES_SVH

`ifndef ASSERT_OFF
`define PCR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define PCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PCR_ASSERT(lbl, clk, rst_n, prop)
`define PCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/pcr_pkg.sv =====
// Types and constants of the packet command responder
package pcr_pkg;

    localparam int ACK_BIT = 7;

    localparam logic [6:0] OP_STARTUP = 7'h04;
    localparam logic [6:0] OP_SPECIAL = 7'h09;
    localparam logic [6:0] OP_UNITNUM = 7'h0B;

    localparam logic [7:0] CHAR_V  = 8'h76;
    localparam logic [7:0] CHAR_X  = 8'h78;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    localparam logic [7:0] VERSION_MAJOR = 8'd1;
    localparam logic [7:0] VERSION_MINOR = 8'd0;

    localparam logic [7:0] UNIT_SEL_GET = 8'd1;
    localparam logic [7:0] UNIT_SEL_SET = 8'd2;

    localparam logic [15:0] UNIT_RESET = 16'd4718;

    // Slots of a reply plan, emitted from the lowest set bit upwards
    localparam int PLAN_STARTUP = 0;
    localparam int PLAN_VERSION = 1;
    localparam int PLAN_UNIT    = 2;
    localparam int PLAN_ECHO    = 3;
    localparam int PLAN_W       = 4;

    typedef struct packed {
        logic [7:0] cmd_byte;
        logic [7:0] param_one;
        logic [7:0] param_two;
        logic [7:0] param_three;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_cmd;
        logic [7:0] out_p1;
        logic [7:0] out_p2;
        logic [7:0] out_p3;
        logic       last_of_run;
    } out_word_t;

    // Classified command: echo packet (command byte already adjusted),
    // reply plan and whether it loads the unit number
    typedef struct packed {
        in_word_t          echo;
        logic [PLAN_W-1:0] plan;
        logic              set_unit;
    } job_t;

endpackage

// ===== sv/packet_command_responder.sv =====
// Top level of the packet command responder
//
//   port group          direction  word type    meaning
//   s_valid/s_ready     in         in_word_t    one decoded command packet
//   m_valid/m_ready     out        out_word_t   one reply packet, last_of_run on the final one
//
// Each reply packet is one word from the output sequencer; a command with no
// reply still passes through the sequencer, and a command yields 0 to 4 replies.
// Commands wait in a queue of QUEUE_DEPTH words while the sequencer is busy;
// s_ready falls only when that queue is full.
// Reset is synchronous on aresetn low and sets the unit number to 4718.
// A stalled m_ready holds the output word and backs up the queue.
module packet_command_responder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pcr_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output pcr_pkg::out_word_t m_word
);
    import pcr_pkg::*;

    job_t front_job;
    job_t head_job;
    logic head_valid;
    logic head_pop;

    pcr_front u_front (
        .in_word (s_word),
        .job     (front_job)
    );

    pcr_job_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_job   (front_job),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .rd_job   (head_job),
        .rd_valid (head_valid),
        .rd_pop   (head_pop)
    );

    pcr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_job   (head_job),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .m_word     (m_word),
        .m_valid    (m_valid),
        .m_ready    (m_ready)
    );

endmodule

// ===== sv/pcr_front.sv =====
// Front end: decodes an incoming command word into a reply plan
module pcr_front (
    input  pcr_pkg::in_word_t in_word,
    output pcr_pkg::job_t     job
);
    import pcr_pkg::*;

    logic [6:0] opcode;
    logic       ok;
    logic [PLAN_W-1:0] plan;
    logic       set_unit;

    assign opcode = in_word.cmd_byte[6:0];

    always_comb begin
        ok       = 1'b0;
        plan     = '0;
        set_unit = 1'b0;
        unique case (opcode)
            OP_STARTUP: begin
                if (in_word.param_one == 8'd0 && in_word.param_two == 8'd0 &&
                    in_word.param_three == 8'd0) begin
                    ok = 1'b1;
                    plan[PLAN_STARTUP] = 1'b1;
                    plan[PLAN_VERSION] = 1'b1;
                    plan[PLAN_UNIT]    = 1'b1;
                end
            end
            OP_SPECIAL: begin
                if (in_word.param_one == CHAR_V && in_word.param_two == CHAR_X &&
                    in_word.param_three == CHAR_CR) begin
                    ok = 1'b1;
                    plan[PLAN_VERSION] = 1'b1;
                end
            end
            OP_UNITNUM: begin
                if (in_word.param_one == UNIT_SEL_GET && in_word.param_two == 8'd0 &&
                    in_word.param_three == 8'd0) begin
                    ok = 1'b1;
                    plan[PLAN_UNIT] = 1'b1;
                end else if (in_word.param_one == UNIT_SEL_SET) begin
                    ok       = 1'b1;
                    set_unit = 1'b1;
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        plan[PLAN_ECHO] = in_word.cmd_byte[ACK_BIT];
    end

    always_comb begin
        job.echo          = in_word;
        // drop the acknowledge bit from the echo on failure
        job.echo.cmd_byte = ok ? in_word.cmd_byte : {1'b0, in_word.cmd_byte[6:0]};
        job.plan          = plan;
        job.set_unit      = set_unit;
    end

endmodule

// ===== sv/pcr_job_fifo.sv =====
// Short queue of classified commands between front and back end
`include "packet_command_responder_defines.svh"
module pcr_job_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  pcr_pkg::job_t  wr_job,
    input  logic           wr_valid,
    output logic           wr_ready,
    output pcr_pkg::job_t  rd_job,
    output logic           rd_valid,
    input  logic           rd_pop
);
    import pcr_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_job   = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

    `PCR_ASSERT(a_count_bounded, aclk, aresetn, count_reg <= FULL_CNT)
    `PCR_ASSERT_NEXT(a_push_grows, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `PCR_ASSERT_NEXT(a_pop_shrinks, aclk, aresetn, pop && !push, count_reg == $past(count_reg) - 1'b1)

endmodule

// ===== sv/pcr_back.sv =====
// Back end: holds the unit number and emits the reply words of each command
`include "packet_command_responder_defines.svh"
module pcr_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  pcr_pkg::job_t      head_job,
    input  logic               head_valid,
    output logic               head_pop,
    output pcr_pkg::out_word_t m_word,
    output logic               m_valid,
    input  logic               m_ready
);
    import pcr_pkg::*;

    logic [PLAN_W-1:0] pend_reg, pend_next;
    job_t              cur_reg;
    logic [15:0]       unit_reg;
    out_word_t         m_word_reg, m_word_next;
    logic              m_valid_reg, m_valid_next;

    logic              advance, have, load;
    job_t              item;
    logic [PLAN_W-1:0] mask, low;

    assign advance  = !m_valid_reg || m_ready;
    assign have     = (pend_reg != '0);
    assign load     = !have && head_valid && advance;
    assign head_pop = load;
    assign item     = have ? cur_reg : head_job;
    assign mask     = have ? pend_reg : (head_valid ? head_job.plan : '0);
    assign low      = mask & (~mask + 1'b1);

    always_comb begin
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        if (advance) begin
            pend_next    = mask & ~low;
            m_valid_next = (mask != '0);
            if (low[PLAN_STARTUP]) begin
                m_word_next.out_cmd = {1'b0, OP_STARTUP};
                m_word_next.out_p1  = 8'd0;
                m_word_next.out_p2  = 8'd0;
                m_word_next.out_p3  = 8'd0;
            end else if (low[PLAN_VERSION]) begin
                m_word_next.out_cmd = {1'b0, OP_SPECIAL};
                m_word_next.out_p1  = CHAR_V;
                m_word_next.out_p2  = VERSION_MAJOR;
                m_word_next.out_p3  = VERSION_MINOR;
            end else if (low[PLAN_UNIT]) begin
                m_word_next.out_cmd = {1'b0, OP_UNITNUM};
                m_word_next.out_p1  = UNIT_SEL_GET;
                m_word_next.out_p2  = unit_reg[7:0];
                m_word_next.out_p3  = unit_reg[15:8];
            end else begin
                m_word_next.out_cmd = item.echo.cmd_byte;
                m_word_next.out_p1  = item.echo.param_one;
                m_word_next.out_p2  = item.echo.param_two;
                m_word_next.out_p3  = item.echo.param_three;
            end
            m_word_next.last_of_run = ((mask & ~low) == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
            unit_reg    <= UNIT_RESET;
        end else begin
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            // load the unit number as the set command leaves the queue
            if (load && head_job.set_unit) begin
                unit_reg <= {head_job.echo.param_three, head_job.echo.param_two};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cur_reg <= head_job;
        end
        m_word_reg <= m_word_next;
    end

    assign m_word  = m_word_reg;
    assign m_valid = m_valid_reg;

    `PCR_ASSERT(a_startup_first, aclk, aresetn, !pend_reg[PLAN_STARTUP])
    `PCR_ASSERT(a_last_drains_plan, aclk, aresetn, !(m_valid_reg && m_word_reg.last_of_run) || pend_reg == '0)
    `PCR_ASSERT_NEXT(a_unit_only_on_set, aclk, aresetn, !(load && head_job.set_unit), $stable(unit_reg))

endmodule

// ===== sim/packet_command_responder_test.sv =====
// Self-checking testbench for the packet command responder
`timescale 1ns / 1ps

module packet_command_responder_test;
    import pcr_pkg::*;

    localparam int RANDOM_CMDS = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    in_word_t  pending_cmds[$];
    out_word_t expected_replies[$];
    out_word_t want;
    logic [15:0] unit_no = UNIT_RESET;
    logic      s_taken = 1'b0;
    int        total_cmds = 0;
    int        issued_cnt = 0;
    int        taken_cnt = 0;
    int        err_cnt = 0;
    int        quiet_cycles = 0;

    packet_command_responder u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [7:0] command_byte(input logic ack, input logic [6:0] op);
        return {ack, op};
    endfunction

    function automatic out_word_t reply_word(input logic [7:0] c, input logic [7:0] a,
                                             input logic [7:0] b, input logic [7:0] d);
        return {c, a, b, d, 1'b0};
    endfunction

    // Work out the reply packets for one command and update the unit number
    task automatic predict_replies(input in_word_t w);
        out_word_t  pkts[$];
        out_word_t  pkt;
        logic [6:0] op;
        logic       ok;
        op = w.cmd_byte[6:0];
        ok = 1'b0;
        if (op == OP_STARTUP) begin
            if (w.param_one == 8'd0 && w.param_two == 8'd0 && w.param_three == 8'd0) begin
                pkts.push_back(reply_word({1'b0, OP_STARTUP}, 8'd0, 8'd0, 8'd0));
                pkts.push_back(reply_word({1'b0, OP_SPECIAL}, CHAR_V, VERSION_MAJOR,
                                          VERSION_MINOR));
                pkts.push_back(reply_word({1'b0, OP_UNITNUM}, UNIT_SEL_GET, unit_no[7:0],
                                          unit_no[15:8]));
                ok = 1'b1;
            end
        end else if (op == OP_SPECIAL) begin
            if (w.param_one == CHAR_V && w.param_two == CHAR_X && w.param_three == CHAR_CR) begin
                pkts.push_back(reply_word({1'b0, OP_SPECIAL}, CHAR_V, VERSION_MAJOR,
                                          VERSION_MINOR));
                ok = 1'b1;
            end
        end else if (op == OP_UNITNUM) begin
            if (w.param_one == UNIT_SEL_GET && w.param_two == 8'd0 && w.param_three == 8'd0) begin
                pkts.push_back(reply_word({1'b0, OP_UNITNUM}, UNIT_SEL_GET, unit_no[7:0],
                                          unit_no[15:8]));
                ok = 1'b1;
            end else if (w.param_one == UNIT_SEL_SET) begin
                unit_no = {w.param_three, w.param_two};
                ok = 1'b1;
            end
        end
        // echo goes last; a failed command loses its acknowledge bit
        if (w.cmd_byte[ACK_BIT])
            pkts.push_back(reply_word(ok ? w.cmd_byte : {1'b0, w.cmd_byte[6:0]},
                                      w.param_one, w.param_two, w.param_three));
        foreach (pkts[i]) begin
            pkt = pkts[i];
            pkt.last_of_run = (i == pkts.size() - 1);
            expected_replies.push_back(pkt);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %02h, want %02h", name, got, exp_val));
    endtask

    task automatic add_cmd(input logic [7:0] c, input logic [7:0] a, input logic [7:0] b,
                           input logic [7:0] d);
        pending_cmds.push_back({c, a, b, d});
    endtask

    // Mostly well-formed commands with random content, some broken, some pure noise
    task automatic add_random_cmd();
        in_word_t w;
        logic     ack;
        int       kind;
        int       slot;
        ack = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: begin
                w = {command_byte(ack, OP_STARTUP), 24'd0};
            end
            1: begin
                w = {command_byte(ack, OP_SPECIAL), CHAR_V, CHAR_X, CHAR_CR};
            end
            2: begin
                w = {command_byte(ack, OP_UNITNUM), UNIT_SEL_GET, 16'd0};
            end
            default: begin
                w = {command_byte(ack, OP_UNITNUM), UNIT_SEL_SET, 16'($urandom)};
            end
        endcase
        kind = $urandom_range(0, 9);
        if (kind == 8) begin
            slot = $urandom_range(0, 3);
            w[slot*8 +: 8] = w[slot*8 +: 8] ^ 8'($urandom_range(1, 255));
        end else if (kind == 9) begin
            w = $urandom;
        end
        pending_cmds.push_back(w);
    endtask

    function automatic int idle_pct(input logic sender);
        int ph;
        ph = (total_cmds == 0) ? 0 : (issued_cnt * 3) / total_cmds;
        case (ph)
            0: return sender ? 17 : 58;
            1: return sender ? 58 : 17;
            default: return 0;
        endcase
    endfunction

    function automatic logic holds_back(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Driver: advance to the next word only once the current one is taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || s_taken) begin
                if (pending_cmds.size() != 0 && !holds_back(idle_pct(1'b1))) begin
                    s_word  <= pending_cmds.pop_front();
                    s_valid <= 1'b1;
                    issued_cnt++;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= !holds_back(idle_pct(1'b0));
        end
    end

    // Monitor: predict on every accepted command, check every accepted reply
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_taken <= 1'b0;
        end else begin
            s_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                predict_replies(s_word);
                taken_cnt++;
            end
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("reply word with nothing expected");
                end else begin
                    want = expected_replies.pop_front();
                    check_field("out_cmd", m_word.out_cmd, want.out_cmd);
                    check_field("out_p1", m_word.out_p1, want.out_p1);
                    check_field("out_p2", m_word.out_p2, want.out_p2);
                    check_field("out_p3", m_word.out_p3, want.out_p3);
                    check_field("last_of_run", {7'd0, m_word.last_of_run},
                                {7'd0, want.last_of_run});
                end
            end
        end
    end

    // Watchdog: drop out if no word moves on either side for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("FAIL packet_command_responder");
                $finish;
            end
        end
    end

    initial begin
        // startup, plain and acknowledged, then broken
        add_cmd(command_byte(1'b0, OP_STARTUP), 8'd0, 8'd0, 8'd0);
        add_cmd(command_byte(1'b1, OP_STARTUP), 8'd0, 8'd0, 8'd0);
        add_cmd(command_byte(1'b1, OP_STARTUP), 8'd0, 8'd0, 8'd1);
        add_cmd(command_byte(1'b0, OP_STARTUP), 8'hFF, 8'd0, 8'd0);
        // version query
        add_cmd(command_byte(1'b0, OP_SPECIAL), CHAR_V, CHAR_X, CHAR_CR);
        add_cmd(command_byte(1'b1, OP_SPECIAL), CHAR_V, CHAR_X, CHAR_CR);
        add_cmd(command_byte(1'b1, OP_SPECIAL), CHAR_V, CHAR_X, 8'd0);
        // unit number get and set, silent set first
        add_cmd(command_byte(1'b0, OP_UNITNUM), UNIT_SEL_GET, 8'd0, 8'd0);
        add_cmd(command_byte(1'b1, OP_UNITNUM), UNIT_SEL_GET, 8'd0, 8'd0);
        add_cmd(command_byte(1'b0, OP_UNITNUM), UNIT_SEL_SET, 8'h34, 8'h12);
        add_cmd(command_byte(1'b0, OP_UNITNUM), UNIT_SEL_GET, 8'd0, 8'd0);
        add_cmd(command_byte(1'b1, OP_UNITNUM), UNIT_SEL_SET, 8'hFF, 8'hFF);
        add_cmd(command_byte(1'b1, OP_STARTUP), 8'd0, 8'd0, 8'd0);
        add_cmd(command_byte(1'b1, OP_UNITNUM), UNIT_SEL_SET, 8'd0, 8'd0);
        add_cmd(command_byte(1'b0, OP_UNITNUM), UNIT_SEL_GET, 8'd0, 8'd0);
        add_cmd(command_byte(1'b1, OP_UNITNUM), 8'd3, 8'd0, 8'd0);
        add_cmd(command_byte(1'b0, OP_UNITNUM), UNIT_SEL_GET, 8'd0, 8'd1);
        // unknown opcodes and all-ones
        add_cmd(8'h00, 8'd0, 8'd0, 8'd0);
        add_cmd(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        add_cmd(8'h80, 8'd0, 8'd0, 8'd0);
        add_cmd(8'h7F, 8'hAA, 8'h55, 8'hAA);
        add_cmd(command_byte(1'b1, OP_UNITNUM), UNIT_SEL_SET, UNIT_RESET[7:0], UNIT_RESET[15:8]);
        add_cmd(command_byte(1'b1, OP_UNITNUM), UNIT_SEL_GET, 8'd0, 8'd0);
        repeat (RANDOM_CMDS) add_random_cmd();
        total_cmds = pending_cmds.size();

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (taken_cnt != total_cmds || expected_replies.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (err_cnt == 0)
            $display("PASS packet_command_responder");
        else
            $display("FAIL packet_command_responder");
        $finish;
    end

endmodule
